### hw/rtl/bfk_pkg.sv
// ----------------------------------------------------------------------------
// bfk_pkg
// Shared types, constants and helpers of the Blowfish-style cipher engine.
// ----------------------------------------------------------------------------
package bfk_pkg;

   localparam int TABLE_WORDS = 1042;
   localparam int P_WORDS     = 18;
   localparam int ROUNDS      = 16;
   localparam int SBOX_WORDS  = TABLE_WORDS - P_WORDS;
   localparam int TIDX_W      = $clog2(TABLE_WORDS);
   localparam int SADDR_W     = $clog2(SBOX_WORDS);
   localparam int PIDX_W      = $clog2(P_WORDS);
   localparam int RCNT_W      = $clog2(ROUNDS);

   localparam logic [PIDX_W-1:0] P_FIRST_A = PIDX_W'(0);
   localparam logic [PIDX_W-1:0] P_FIRST_B = PIDX_W'(1);
   localparam logic [PIDX_W-1:0] P_LAST_A  = PIDX_W'(16);
   localparam logic [PIDX_W-1:0] P_LAST_B  = PIDX_W'(17);

   typedef enum logic [1:0] {
      FUNC_LOAD,
      FUNC_KEY_INIT,
      FUNC_ENCRYPT,
      FUNC_DECRYPT
   } func_type;

   typedef enum logic [2:0] {
      CI_IDLE,
      CI_XOR,
      CI_RD,
      CI_ACC,
      CI_FIN_A,
      CI_FIN_B,
      CI_DONE
   } ci_state_type;

   typedef enum logic [3:0] {
      T_IDLE,
      T_COPY,
      T_PASSSEL,
      T_K1_GO,
      T_K1_WAIT,
      T_K2_GO,
      T_K2_WAIT,
      T_PXOR,
      T_CH_GO,
      T_CH_WAIT,
      T_CH_WR2,
      T_BLK_GO,
      T_BLK_WAIT,
      T_DONE
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic dec;
   } ci_ctl_type;

   function automatic logic [31:0] bswap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

### hw/rtl/bfk_ram.sv
// ----------------------------------------------------------------------------
// bfk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bfk_round.sv
// ----------------------------------------------------------------------------
// bfk_round
// Iterative 16-round Feistel unit: one S-box read and one accumulate a step.
// ----------------------------------------------------------------------------
module bfk_round (
   input  logic                       clock,
   input  logic                       reset,
   input  bfk_pkg::ci_ctl_type        ctl,
   input  logic [31:0]                in_first,
   input  logic [31:0]                in_second,
   output logic                       done,
   output logic [31:0]                out_first,
   output logic [31:0]                out_second,
   output logic [bfk_pkg::PIDX_W-1:0] p_idx,
   input  logic [31:0]                p_data,
   output logic                       sbox_rd_en,
   output logic [bfk_pkg::SADDR_W-1:0] sbox_rd_addr,
   input  logic [31:0]                sbox_rd_data
);
   import bfk_pkg::*;

   ci_state_type      state_ff, state_in;
   logic [31:0]       a_ff, a_in, b_ff, b_in, z_ff, z_in, v_ff, v_in;
   logic [31:0]       of_ff, of_in, os_ff, os_in;
   logic [RCNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        j_ff, j_in;
   logic              dec_ff, dec_in;
   logic [PIDX_W-1:0] round_idx;
   logic [7:0]        zbyte;
   logic [31:0]       f_val;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CI_IDLE:  if (ctl.start) state_in = CI_XOR;
         CI_XOR:   state_in = CI_RD;
         CI_RD:    state_in = CI_ACC;
         CI_ACC: begin
            if (j_ff == 2'd3) begin
               state_in = (cnt_ff == RCNT_W'(ROUNDS - 1)) ? CI_FIN_A : CI_XOR;
            end else begin
               state_in = CI_RD;
            end
         end
         CI_FIN_A: state_in = CI_FIN_B;
         CI_FIN_B: state_in = CI_DONE;
         CI_DONE:  state_in = CI_IDLE;
         default:  state_in = CI_IDLE;
      endcase
   end

   always_comb begin
      round_idx = dec_ff ? (P_LAST_B - PIDX_W'(cnt_ff)) : PIDX_W'(cnt_ff);
      case (j_ff)
         2'd0:    zbyte = z_ff[31:24];
         2'd1:    zbyte = z_ff[23:16];
         2'd2:    zbyte = z_ff[15:8];
         default: zbyte = z_ff[7:0];
      endcase
      case (state_ff)
         CI_FIN_A: p_idx = dec_ff ? P_FIRST_B : P_LAST_A;
         CI_FIN_B: p_idx = dec_ff ? P_FIRST_A : P_LAST_B;
         default:  p_idx = round_idx;
      endcase
      sbox_rd_en   = (state_ff == CI_RD);
      sbox_rd_addr = {j_ff, zbyte};
      done         = (state_ff == CI_DONE);
      out_first    = of_ff;
      out_second   = os_ff;
   end

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      z_in   = z_ff;
      v_in   = v_ff;
      of_in  = of_ff;
      os_in  = os_ff;
      cnt_in = cnt_ff;
      j_in   = j_ff;
      dec_in = dec_ff;
      case (j_ff)
         2'd0:    f_val = sbox_rd_data;
         2'd1:    f_val = sbox_rd_data + v_ff;
         2'd2:    f_val = sbox_rd_data ^ v_ff;
         default: f_val = sbox_rd_data + v_ff;
      endcase
      case (state_ff)
         CI_IDLE: begin
            if (ctl.start) begin
               a_in   = in_second;
               b_in   = in_first;
               dec_in = ctl.dec;
               cnt_in = '0;
            end
         end
         CI_XOR: begin
            z_in = p_data ^ a_ff;
            j_in = 2'd0;
         end
         CI_ACC: begin
            v_in = f_val;
            if (j_ff == 2'd3) begin
               a_in   = b_ff ^ f_val;
               b_in   = z_ff;
               cnt_in = cnt_ff + RCNT_W'(1);
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         CI_FIN_A: of_in = a_ff ^ p_data;
         CI_FIN_B: os_in = b_ff ^ p_data;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CI_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      z_ff   <= z_in;
      v_ff   <= v_in;
      of_ff  <= of_in;
      os_ff  <= os_in;
      cnt_ff <= cnt_in;
      j_ff   <= j_in;
      dec_ff <= dec_in;
   end

endmodule

### hw/rtl/blowfish_key1_cipher_engine_core.sv
// ----------------------------------------------------------------------------
// blowfish_key1_cipher_engine_core
// Blowfish-style 64-bit cipher engine with seed table, key schedule and
// encrypt/decrypt of one block per item.
// ----------------------------------------------------------------------------
//  channel  direction  tdata / tuser
//  req      in         seed load, key init, encrypt or decrypt command
//  rsp      out        64-bit result block (zero for load and key init)
//
//  Encrypt/decrypt: rounds run in the shared round unit (one S-box RAM
//  port, four reads a round). Key init: table copy plus per pass 523
//  encryptions. Reset is synchronous; tables hold no value until loaded
//  or built. req_tready is high only when idle; a waiting result holds
//  the next item in its final state until the output frees.
// ----------------------------------------------------------------------------
module blowfish_key1_cipher_engine_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // table_index, table_word, game_code, key_level, block_first, block_second
   input  logic [143:0] req_tdata,
   // func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_first, out_second
   output logic [63:0]  rsp_tdata
);
   import bfk_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [31:0]        kw0_ff, kw0_in, kw1_ff, kw1_in, kw2_ff, kw2_in;
   logic [1:0]         level_ff, level_in, pc_ff, pc_in;
   logic               shifted_ff, shifted_in;
   logic [TIDX_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]        c0_ff, c0_in, c1_ff, c1_in;
   logic [31:0]        blk_first_ff, blk_first_in, blk_second_ff, blk_second_in;
   logic               blk_dec_ff, blk_dec_in;
   logic [31:0]        res_first_ff, res_first_in, res_second_ff, res_second_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [31:0]        p_ff [P_WORDS];
   logic [31:0]        p_in [P_WORDS];

   logic               accept;
   func_type           func;
   logic [TIDX_W-1:0]  f_index;
   logic [31:0]        f_word, f_code, f_first, f_second;
   logic [1:0]         f_level;
   logic               pass_go, out_free;

   ci_ctl_type         ci_ctl;
   logic [31:0]        ci_in_first, ci_in_second, ci_out_first, ci_out_second;
   logic               ci_done;
   logic [PIDX_W-1:0]  ci_p_idx;
   logic               sbox_rd_en;
   logic [SADDR_W-1:0] sbox_rd_addr;
   logic [31:0]        sbox_rd_data;

   logic               seed_wr_en, seed_rd_en;
   logic [31:0]        seed_rd_data;
   logic               tw_en;
   logic [TIDX_W-1:0]  tw_idx;
   logic [31:0]        tw_data;
   logic               sbox_wr_en;
   logic [SADDR_W-1:0] sbox_wr_addr;

   assign func     = func_type'(req_tuser);
   assign f_index  = req_tdata[10:0];
   assign f_word   = req_tdata[42:11];
   assign f_code   = req_tdata[74:43];
   assign f_level  = req_tdata[76:75];
   assign f_first  = req_tdata[108:77];
   assign f_second = req_tdata[140:109];

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pass_go    = ((pc_ff == 2'd0) && (level_ff >= 2'd1)) ||
                       ((pc_ff == 2'd1) && (level_ff >= 2'd2));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_LOAD:     state_in = T_DONE;
                  FUNC_KEY_INIT: state_in = T_COPY;
                  default:       state_in = T_BLK_GO;
               endcase
            end
         end
         T_COPY:     if (cnt_ff == TIDX_W'(TABLE_WORDS)) state_in = T_PASSSEL;
         T_PASSSEL: begin
            if (pass_go) begin
               state_in = T_K1_GO;
            end else if (!shifted_ff && (level_ff == 2'd3)) begin
               state_in = T_K1_GO;
            end else begin
               state_in = T_DONE;
            end
         end
         T_K1_GO:    state_in = T_K1_WAIT;
         T_K1_WAIT:  if (ci_done) state_in = T_K2_GO;
         T_K2_GO:    state_in = T_K2_WAIT;
         T_K2_WAIT:  if (ci_done) state_in = T_PXOR;
         T_PXOR:     state_in = T_CH_GO;
         T_CH_GO:    state_in = T_CH_WAIT;
         T_CH_WAIT:  if (ci_done) state_in = T_CH_WR2;
         T_CH_WR2: begin
            state_in = (cnt_ff + TIDX_W'(2) == TIDX_W'(TABLE_WORDS)) ? T_PASSSEL : T_CH_GO;
         end
         T_BLK_GO:   state_in = T_BLK_WAIT;
         T_BLK_WAIT: if (ci_done) state_in = T_DONE;
         T_DONE:     if (out_free) state_in = T_IDLE;
         default:    state_in = T_IDLE;
      endcase
   end

   always_comb begin
      ci_ctl.start = (state_ff == T_K1_GO) || (state_ff == T_K2_GO) ||
                     (state_ff == T_CH_GO) || (state_ff == T_BLK_GO);
      ci_ctl.dec   = (state_ff == T_BLK_GO) && blk_dec_ff;
      case (state_ff)
         T_K1_GO: begin
            ci_in_first  = kw1_ff;
            ci_in_second = kw2_ff;
         end
         T_K2_GO: begin
            ci_in_first  = kw0_ff;
            ci_in_second = kw1_ff;
         end
         T_CH_GO: begin
            ci_in_first  = c0_ff;
            ci_in_second = c1_ff;
         end
         default: begin
            ci_in_first  = blk_first_ff;
            ci_in_second = blk_second_ff;
         end
      endcase
      seed_wr_en = accept && (func == FUNC_LOAD) && (f_index < TIDX_W'(TABLE_WORDS));
      seed_rd_en = (state_ff == T_COPY) && (cnt_ff < TIDX_W'(TABLE_WORDS));
      tw_en   = 1'b0;
      tw_idx  = cnt_ff;
      tw_data = ci_out_second;
      case (state_ff)
         T_COPY: begin
            tw_en   = (cnt_ff != '0);
            tw_idx  = cnt_ff - TIDX_W'(1);
            tw_data = seed_rd_data;
         end
         T_CH_WAIT: tw_en = ci_done;
         T_CH_WR2: begin
            tw_en   = 1'b1;
            tw_idx  = cnt_ff + TIDX_W'(1);
            tw_data = c0_ff;
         end
         default: ;
      endcase
      sbox_wr_en   = tw_en && (tw_idx >= TIDX_W'(P_WORDS));
      sbox_wr_addr = SADDR_W'(tw_idx - TIDX_W'(P_WORDS));
   end

   always_comb begin
      kw0_in        = kw0_ff;
      kw1_in        = kw1_ff;
      kw2_in        = kw2_ff;
      level_in      = level_ff;
      pc_in         = pc_ff;
      shifted_in    = shifted_ff;
      cnt_in        = cnt_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      blk_first_in  = blk_first_ff;
      blk_second_in = blk_second_ff;
      blk_dec_in    = blk_dec_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      for (int i = 0; i < P_WORDS; i++) begin
         p_in[i] = p_ff[i];
      end
      if (tw_en && (tw_idx < TIDX_W'(P_WORDS))) begin
         p_in[tw_idx[PIDX_W-1:0]] = tw_data;
      end
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               res_first_in  = '0;
               res_second_in = '0;
               kw0_in        = (func == FUNC_KEY_INIT) ? f_code : kw0_ff;
               kw1_in        = (func == FUNC_KEY_INIT) ? (f_code >> 1) : kw1_ff;
               kw2_in        = (func == FUNC_KEY_INIT) ? (f_code << 1) : kw2_ff;
               level_in      = f_level;
               pc_in         = '0;
               shifted_in    = 1'b0;
               cnt_in        = '0;
               blk_first_in  = f_first;
               blk_second_in = f_second;
               blk_dec_in    = (func == FUNC_DECRYPT);
            end
         end
         T_COPY:    cnt_in = cnt_ff + TIDX_W'(1);
         T_PASSSEL: begin
            if (!pass_go && !shifted_ff) begin
               kw1_in     = kw1_ff << 1;
               kw2_in     = kw2_ff >> 1;
               shifted_in = 1'b1;
            end
         end
         T_K1_WAIT: begin
            if (ci_done) begin
               kw1_in = ci_out_first;
               kw2_in = ci_out_second;
            end
         end
         T_K2_WAIT: begin
            if (ci_done) begin
               kw0_in = ci_out_first;
               kw1_in = ci_out_second;
            end
         end
         T_PXOR: begin
            for (int i = 0; i < P_WORDS; i++) begin
               p_in[i] = p_ff[i] ^ bswap((i % 2 == 1) ? kw1_ff : kw0_ff);
            end
            c0_in  = '0;
            c1_in  = '0;
            cnt_in = '0;
         end
         T_CH_WAIT: begin
            if (ci_done) begin
               c0_in = ci_out_first;
               c1_in = ci_out_second;
            end
         end
         T_CH_WR2: begin
            cnt_in = cnt_ff + TIDX_W'(2);
            if (cnt_ff + TIDX_W'(2) == TIDX_W'(TABLE_WORDS)) begin
               pc_in = pc_ff + 2'd1;
            end
         end
         T_BLK_WAIT: begin
            if (ci_done) begin
               res_first_in  = ci_out_first;
               res_second_in = ci_out_second;
            end
         end
         T_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_second_ff, res_first_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         kw0_ff       <= '0;
         kw1_ff       <= '0;
         kw2_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kw0_ff       <= kw0_in;
         kw1_ff       <= kw1_in;
         kw2_ff       <= kw2_in;
      end
      level_ff      <= level_in;
      pc_ff         <= pc_in;
      shifted_ff    <= shifted_in;
      cnt_ff        <= cnt_in;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      blk_first_ff  <= blk_first_in;
      blk_second_ff <= blk_second_in;
      blk_dec_ff    <= blk_dec_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      rsp_data_ff   <= rsp_data_in;
      for (int i = 0; i < P_WORDS; i++) begin
         p_ff[i] <= p_in[i];
      end
   end

   bfk_ram #(
      .WIDTH(32),
      .DEPTH(TABLE_WORDS)
   ) u_seed_ram (
      .clock   (clock),
      .wr_en   (seed_wr_en),
      .wr_addr (f_index),
      .wr_data (f_word),
      .rd_en   (seed_rd_en),
      .rd_addr (cnt_ff),
      .rd_data (seed_rd_data)
   );

   bfk_ram #(
      .WIDTH(32),
      .DEPTH(SBOX_WORDS)
   ) u_sbox_ram (
      .clock   (clock),
      .wr_en   (sbox_wr_en),
      .wr_addr (sbox_wr_addr),
      .wr_data (tw_data),
      .rd_en   (sbox_rd_en),
      .rd_addr (sbox_rd_addr),
      .rd_data (sbox_rd_data)
   );

   bfk_round u_round (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ci_ctl),
      .in_first     (ci_in_first),
      .in_second    (ci_in_second),
      .done         (ci_done),
      .out_first    (ci_out_first),
      .out_second   (ci_out_second),
      .p_idx        (ci_p_idx),
      .p_data       (p_ff[ci_p_idx]),
      .sbox_rd_en   (sbox_rd_en),
      .sbox_rd_addr (sbox_rd_addr),
      .sbox_rd_data (sbox_rd_data)
   );

endmodule
